// ----- rtl/entropy_compression_level_select_top_defines.svh -----
// ----------------------------------------------------------------------------
// Entropy level select assertion macros
// Shared property shapes for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef ENTROPY_COMPRESSION_LEVEL_SELECT_TOP_DEFINES_SVH
`define ENTROPY_COMPRESSION_LEVEL_SELECT_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define ECLS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define ECLS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/ecls_pkg.sv -----
// ----------------------------------------------------------------------------
// Entropy level select package
// Widths, register indexes, levels, state type and control structs.
// ----------------------------------------------------------------------------
package ecls_pkg;

	// Histogram geometry
	localparam int HIST_BINS = 256;
	localparam int BIN_IDX_W = 8;
	localparam int DEF_PAGE_BYTES = 4096;

	// Log2 result: integer part and fraction
	localparam int LOG_K_W = 5;
	localparam int LOG_FRAC_W = 16;
	localparam int LOG_W = LOG_K_W + LOG_FRAC_W;
	localparam int LOG_MANT_W = 32;

	// Field widths
	localparam int BYTE_W = 8;
	localparam int LEVEL_W = 5;
	localparam int ENT_W = 12;
	localparam int LEN_W = 13;
	localparam int IN_TDATA_W = 8;
	localparam int OUT_TDATA_W = 32;

	// Configuration port
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 12;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_OVERRIDE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD = 2'd2;
	localparam logic [ENT_W-1:0] LOW_THRESHOLD_RST = 12'd1024;
	localparam logic [ENT_W-1:0] HIGH_THRESHOLD_RST = 12'd1536;

	// Levels and limits
	localparam logic [LEVEL_W-1:0] LEVEL_FAST = 5'd1;
	localparam logic [LEVEL_W-1:0] LEVEL_MID = 5'd3;
	localparam logic [LEVEL_W-1:0] LEVEL_HIGH = 5'd5;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 5'd22;
	localparam logic [ENT_W-1:0] ENT_MAX = 12'd2048;
	localparam logic [LEN_W-1:0] LEN_MAX = 13'd8191;

	typedef enum logic [3:0] {
		ST_ACCUM,
		ST_DRAIN,
		ST_BIN_CHECK,
		ST_BIN_READ,
		ST_BIN_LOG,
		ST_BIN_ACC,
		ST_N_LOG,
		ST_DIV,
		ST_FINISH
	} ecls_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic byte_take;
		logic bin_clr;
		logic bin_next;
		logic bin_rd;
		logic log_start_bin;
		logic log_start_n;
		logic mul;
		logic acc;
		logic latch_ln;
		logic div_start;
		logic load_out;
		logic page_clr;
	} ecls_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic bin_valid;
		logic bin_last;
		logic log_done;
		logic div_done;
		logic out_free;
	} ecls_sts_t;

endpackage

// ----- rtl/entropy_compression_level_select_top.sv -----
// ----------------------------------------------------------------------------
// Entropy level select top level
// Page byte histogram, Shannon entropy in Q4.8 and compression level choice.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_axis    in         tdata[7:0] data_byte, tlast last_byte
//  m_axis    out        tdata chosen_level, entropy_q8, page_length
//  cfg       in         cfg_index selects level_override, low/high_threshold
//
//  Bytes are taken one per cycle while a page is open.
//  At page end intake stops for the walk: the last histogram write lands, each empty
//  bin is skipped without a read and each used bin is read, its log2 taken and summed,
//  then log2 of the length is taken and the serial divider runs.
//  The result waits in the output register; intake resumes once it is loaded.
//  Reset clears the histogram valid bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "entropy_compression_level_select_top_defines.svh"

module entropy_compression_level_select_top
	import ecls_pkg::*;
#(
	parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic                   s_axis_tlast,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [4:0] chosen_level,
	                                              // [16:5] entropy_q8,
	                                              // [29:17] page_length
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	ecls_cmd_t          cmd;
	ecls_sts_t          sts;
	logic [LEVEL_W-1:0] chosen_level;
	logic [ENT_W-1:0]   entropy_q8;
	logic [LEN_W-1:0]   page_length;
	logic               in_last_xfer;
	logic               level_ok;

	ecls_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_last  (s_axis_tlast),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ecls_dp #(
		.PAGE_BYTES (PAGE_BYTES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.data_byte    (s_axis_tdata[BYTE_W-1:0]),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_ready    (m_axis_tready),
		.out_valid    (m_axis_tvalid),
		.chosen_level (chosen_level),
		.entropy_q8   (entropy_q8),
		.page_length  (page_length)
	);

	assign m_axis_tdata = {2'b00, page_length, entropy_q8, chosen_level};

	// Checks on the block's own results and intake control.
	assign in_last_xfer = s_axis_tvalid && s_axis_tready && s_axis_tlast;
	assign level_ok     = (chosen_level != '0) && (chosen_level <= LEVEL_MAX);

	`ECLS_ASSERT_NEXT(a_stop_after_last, in_last_xfer, !s_axis_tready, "intake not stopped")
	`ECLS_ASSERT_SAME(a_level_range, m_axis_tvalid, level_ok, "level out of range")
	`ECLS_ASSERT_SAME(a_entropy_range, m_axis_tvalid, entropy_q8 <= ENT_MAX, "entropy too high")
	`ECLS_ASSERT_SAME(a_length_nonzero, m_axis_tvalid, page_length != '0, "empty page result")

endmodule

// ----- rtl/ecls_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ecls_ram #(
	parameter int WIDTH = 13,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Read returns the contents before a write in the same cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/ecls_log2.sv -----
// ----------------------------------------------------------------------------
// Entropy level select log2 unit
// Bit-serial log2 in Q.16 by repeated squaring, one fraction bit a cycle.
// ----------------------------------------------------------------------------
module ecls_log2
	import ecls_pkg::*;
#(
	parameter int X_W = 13
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [X_W-1:0]   x,
	output logic             done,
	output logic [LOG_W-1:0] result
);

	logic [LOG_K_W-1:0]      k_q;
	logic [LOG_FRAC_W-1:0]   frac_q;
	logic [LOG_MANT_W-1:0]   m_q;
	logic [3:0]              iter_q;
	logic                    busy_q;
	logic                    done_q;
	logic [LOG_K_W-1:0]      k_msb;
	logic [LOG_MANT_W-1:0]   m_norm;
	logic [2*LOG_MANT_W-1:0] sq;
	logic [LOG_MANT_W:0]     sq_top;

	// Index of the most significant set bit of the operand.
	always_comb begin
		k_msb = '0;
		for (int i = 0; i < X_W; i++) begin
			if (x[i]) begin
				k_msb = LOG_K_W'(i);
			end
		end
	end

	assign m_norm = LOG_MANT_W'(x) << (LOG_K_W'(LOG_MANT_W - 1) - k_msb);

	// Square the mantissa and keep it in [1,2) as Q1.31.
	assign sq = 64'(m_q) * 64'(m_q);
	assign sq_top = sq[2*LOG_MANT_W-1:LOG_MANT_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				iter_q <= '0;
			end else if (busy_q) begin
				iter_q <= iter_q + 4'd1;
				if (iter_q == 4'(LOG_FRAC_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					done_q <= 1'b0;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			k_q    <= k_msb;
			m_q    <= m_norm;
			frac_q <= '0;
		end else if (busy_q) begin
			if (sq_top[LOG_MANT_W]) begin
				frac_q <= {frac_q[LOG_FRAC_W-2:0], 1'b1};
				m_q    <= sq_top[LOG_MANT_W:1];
			end else begin
				frac_q <= {frac_q[LOG_FRAC_W-2:0], 1'b0};
				m_q    <= sq_top[LOG_MANT_W-1:0];
			end
		end
	end

	assign done   = done_q;
	assign result = {k_q, frac_q};

endmodule

// ----- rtl/ecls_dp.sv -----
// ----------------------------------------------------------------------------
// Entropy level select datapath
// Histogram update, bin walk, log and divide, level choice and output register.
// ----------------------------------------------------------------------------
module ecls_dp
	import ecls_pkg::*;
#(
	parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ecls_cmd_t              cmd,
	output ecls_sts_t              sts,
	input  logic [BYTE_W-1:0]      data_byte,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic [LEVEL_W-1:0]     chosen_level,
	output logic [ENT_W-1:0]       entropy_q8,
	output logic [LEN_W-1:0]       page_length
);

	localparam int CNT_W = $clog2(PAGE_BYTES + 1);
	localparam int SUM_W = CNT_W + LOG_W;
	localparam int DIV_CNT_W = $clog2(SUM_W + 1);

	// Configuration registers
	logic [LEVEL_W-1:0] override_q;
	logic [ENT_W-1:0]   low_thr_q;
	logic [ENT_W-1:0]   high_thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			override_q <= '0;
			low_thr_q  <= LOW_THRESHOLD_RST;
			high_thr_q <= HIGH_THRESHOLD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LEVEL_OVERRIDE: override_q <= cfg_data[LEVEL_W-1:0];
				REG_LOW_THRESHOLD:  low_thr_q  <= cfg_data[ENT_W-1:0];
				REG_HIGH_THRESHOLD: high_thr_q <= cfg_data[ENT_W-1:0];
				default: ;
			endcase
		end
	end

	// Histogram store and its valid bits
	logic [HIST_BINS-1:0] bin_vld_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [BYTE_W-1:0]    byte_s1;
	logic                 wr_s1;
	logic                 fwd_vld_q;
	logic [BYTE_W-1:0]    fwd_addr_q;
	logic [CNT_W-1:0]     fwd_data_q;
	logic [CNT_W-1:0]     ram_rdata;
	logic [BIN_IDX_W-1:0] ram_raddr;
	logic [CNT_W-1:0]     bin_old;
	logic [CNT_W-1:0]     bin_new;
	logic [BIN_IDX_W-1:0] idx_q;
	logic                 counted;

	assign counted   = cnt_q < CNT_W'(PAGE_BYTES);
	assign ram_raddr = cmd.bin_rd ? idx_q : data_byte;

	// The bin written in the previous cycle is not yet visible in the read data.
	always_comb begin
		if (fwd_vld_q && (fwd_addr_q == byte_s1)) begin
			bin_old = fwd_data_q;
		end else if (bin_vld_q[byte_s1]) begin
			bin_old = ram_rdata;
		end else begin
			bin_old = '0;
		end
	end
	assign bin_new = bin_old + CNT_W'(1);

	ecls_ram #(
		.WIDTH (CNT_W),
		.DEPTH (HIST_BINS)
	) u_hist (
		.clk   (clk),
		.we    (wr_s1),
		.waddr (byte_s1),
		.wdata (bin_new),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_vld_q <= '0;
			cnt_q     <= '0;
			wr_s1     <= 1'b0;
			fwd_vld_q <= 1'b0;
		end else begin
			wr_s1 <= cmd.byte_take && counted;
			if (cmd.page_clr) begin
				bin_vld_q <= '0;
				cnt_q     <= '0;
				fwd_vld_q <= 1'b0;
			end else begin
				fwd_vld_q <= wr_s1;
				if (cmd.byte_take && counted) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
				if (wr_s1) begin
					bin_vld_q[byte_s1] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.byte_take) begin
			byte_s1 <= data_byte;
		end
		fwd_addr_q <= byte_s1;
		fwd_data_q <= bin_new;
	end

	// Bin walk: index, count of the bin, log and weighted sum
	logic [CNT_W-1:0] bin_cnt_q;
	logic [SUM_W-1:0] prod_q;
	logic [SUM_W-1:0] sum_q;
	logic [LOG_W-1:0] ln_q;
	logic [LOG_W-1:0] log_res;
	logic             log_done;
	logic             log_start;
	logic [CNT_W-1:0] log_x;

	assign log_start = cmd.log_start_bin || cmd.log_start_n;
	assign log_x     = cmd.log_start_bin ? ram_rdata : cnt_q;

	ecls_log2 #(
		.X_W (CNT_W)
	) u_log2 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (log_start),
		.x      (log_x),
		.done   (log_done),
		.result (log_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.bin_clr) begin
			idx_q <= '0;
		end else if (cmd.bin_next) begin
			idx_q <= idx_q + BIN_IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.log_start_bin) begin
			bin_cnt_q <= ram_rdata;
		end
		if (cmd.mul) begin
			prod_q <= SUM_W'(bin_cnt_q) * SUM_W'(log_res);
		end
		if (cmd.bin_clr) begin
			sum_q <= '0;
		end else if (cmd.acc) begin
			sum_q <= sum_q + prod_q;
		end
		if (cmd.latch_ln) begin
			ln_q <= log_res;
		end
	end

	// Restoring divider for the mean of the weighted logs, one bit a cycle.
	logic [SUM_W-1:0]     quo_q;
	logic [CNT_W-1:0]     rem_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                 div_busy_q;
	logic                 div_done_q;
	logic [CNT_W:0]       trial;
	logic                 trial_ok;

	assign trial    = {rem_q, quo_q[SUM_W-1]};
	assign trial_ok = trial >= {1'b0, cnt_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_done_q <= 1'b0;
			div_cnt_q  <= '0;
		end else begin
			if (cmd.div_start) begin
				div_busy_q <= 1'b1;
				div_done_q <= 1'b0;
				div_cnt_q  <= '0;
			end else if (div_busy_q) begin
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
				if (div_cnt_q == DIV_CNT_W'(SUM_W - 1)) begin
					div_busy_q <= 1'b0;
					div_done_q <= 1'b1;
				end else begin
					div_done_q <= 1'b0;
				end
			end else begin
				div_done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			quo_q <= sum_q;
			rem_q <= '0;
		end else if (div_busy_q) begin
			if (trial_ok) begin
				rem_q <= CNT_W'(trial - {1'b0, cnt_q});
			end else begin
				rem_q <= trial[CNT_W-1:0];
			end
			quo_q <= {quo_q[SUM_W-2:0], trial_ok};
		end
	end

	// Entropy in Q4.8 with round half up and saturation, then the level.
	logic [SUM_W-1:0]   ln_wide;
	logic [SUM_W-1:0]   h_full;
	logic [SUM_W-1:0]   h_round;
	logic [ENT_W-1:0]   ent;
	logic [LEVEL_W-1:0] lvl;
	logic [LEN_W-1:0]   len;

	assign ln_wide = SUM_W'(ln_q);
	assign h_full  = ln_wide - quo_q;
	assign h_round = (h_full + SUM_W'(128)) >> 8;

	always_comb begin
		if ((cnt_q == '0) || (quo_q > ln_wide)) begin
			ent = '0;
		end else if (h_round > SUM_W'(ENT_MAX)) begin
			ent = ENT_MAX;
		end else begin
			ent = h_round[ENT_W-1:0];
		end

		if (override_q != '0) begin
			lvl = (override_q > LEVEL_MAX) ? LEVEL_MAX : override_q;
		end else if (ent < low_thr_q) begin
			lvl = LEVEL_FAST;
		end else if (ent < high_thr_q) begin
			lvl = LEVEL_MID;
		end else begin
			lvl = LEVEL_HIGH;
		end

		if (32'(cnt_q) > 32'(LEN_MAX)) begin
			len = LEN_MAX;
		end else begin
			len = LEN_W'(32'(cnt_q));
		end
	end

	// Output register; holds one result until it is taken.
	logic out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			chosen_level <= lvl;
			entropy_q8   <= ent;
			page_length  <= len;
		end
	end

	assign out_valid = out_vld_q;

	assign sts.bin_valid = bin_vld_q[idx_q];
	assign sts.bin_last  = idx_q == BIN_IDX_W'(HIST_BINS - 1);
	assign sts.log_done  = log_done;
	assign sts.div_done  = div_done_q;
	assign sts.out_free  = !out_vld_q || out_ready;

endmodule

// ----- rtl/ecls_ctrl.sv -----
// ----------------------------------------------------------------------------
// Entropy level select controller
// Sequences byte intake, the bin walk, the divide and the result hand-over.
// ----------------------------------------------------------------------------
module ecls_ctrl
	import ecls_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_last,
	output logic      in_ready,
	input  ecls_sts_t sts,
	output ecls_cmd_t cmd
);

	ecls_state_t state_q;
	ecls_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCUM;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			// Bytes stream in; the page ends with the byte marked last.
			ST_ACCUM: begin
				in_ready      = 1'b1;
				cmd.byte_take = in_valid;
				if (in_valid && in_last) begin
					state_d = ST_DRAIN;
				end
			end
			// Let the final histogram write land.
			ST_DRAIN: begin
				cmd.bin_clr = 1'b1;
				state_d     = ST_BIN_CHECK;
			end
			// Empty bins are skipped without a read.
			ST_BIN_CHECK: begin
				if (sts.bin_valid) begin
					cmd.bin_rd = 1'b1;
					state_d    = ST_BIN_READ;
				end else if (sts.bin_last) begin
					cmd.log_start_n = 1'b1;
					state_d         = ST_N_LOG;
				end else begin
					cmd.bin_next = 1'b1;
				end
			end
			ST_BIN_READ: begin
				cmd.log_start_bin = 1'b1;
				state_d           = ST_BIN_LOG;
			end
			ST_BIN_LOG: begin
				if (sts.log_done) begin
					cmd.mul = 1'b1;
					state_d = ST_BIN_ACC;
				end
			end
			ST_BIN_ACC: begin
				cmd.acc = 1'b1;
				if (sts.bin_last) begin
					cmd.log_start_n = 1'b1;
					state_d         = ST_N_LOG;
				end else begin
					cmd.bin_next = 1'b1;
					state_d      = ST_BIN_CHECK;
				end
			end
			ST_N_LOG: begin
				if (sts.log_done) begin
					cmd.latch_ln  = 1'b1;
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				if (sts.div_done) begin
					state_d = ST_FINISH;
				end
			end
			// Wait for room in the output register, then start a fresh page.
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					cmd.page_clr = 1'b1;
					state_d      = ST_ACCUM;
				end
			end
			default: begin
				state_d = ST_ACCUM;
			end
		endcase
	end

endmodule

// ----- bench/entropy_compression_level_select_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Entropy level select checker
// Watches the byte stream, the register writes and the result stream, predicts
// each page result from its own histogram and log2 arithmetic, and compares
// every result transfer field by field against the oldest expected one.
// ----------------------------------------------------------------------------
module entropy_compression_level_select_checker
	import ecls_pkg::*;
#(
	parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                   s_axis_tlast,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     fail_count,
	output int                     pending_pages
);

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [ENT_W-1:0]   entropy;
		logic [LEN_W-1:0]   length;
	} page_result_t;

	int unsigned        bin_count [HIST_BINS];
	int unsigned        bytes_seen;
	logic [LEVEL_W-1:0] override_lvl;
	logic [ENT_W-1:0]   thr_low;
	logic [ENT_W-1:0]   thr_high;
	page_result_t       page_results [$];

	// Base-2 logarithm in Q16.16 by repeated squaring of the mantissa.
	function automatic longint unsigned log2_fix(int unsigned x);
		int                 k;
		longint unsigned    m;
		longint unsigned    frac;
		k = 31;
		frac = 0;
		if (x == 0)
			return 0;
		while (x[k] == 1'b0)
			k--;
		m = longint'(x) << (31 - k);
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 31;
			frac = frac << 1;
			if (m >= (64'd1 << 32)) begin
				frac |= 1;
				m = m >> 1;
			end
		end
		return (longint'(k) << 16) | frac;
	endfunction

	// Shannon entropy of the current histogram, rounded to Q4.8 and clamped.
	function automatic logic [ENT_W-1:0] entropy_of_page();
		longint unsigned sum;
		longint unsigned ln;
		longint unsigned avg;
		longint unsigned q;
		sum = 0;
		if (bytes_seen == 0)
			return '0;
		for (int i = 0; i < HIST_BINS; i++) begin
			if (bin_count[i] != 0)
				sum += longint'(bin_count[i]) * log2_fix(bin_count[i]);
		end
		ln = log2_fix(bytes_seen);
		avg = sum / bytes_seen;
		if (avg > ln)
			return '0;
		q = (ln - avg + 128) >> 8;
		if (q > ENT_MAX)
			q = ENT_MAX;
		return q[ENT_W-1:0];
	endfunction

	assign pending_pages = page_results.size();

	always @(posedge clk) begin
		page_result_t want;
		page_result_t got;
		if (!arst_n) begin
			foreach (bin_count[i])
				bin_count[i] = 0;
			bytes_seen = 0;
			override_lvl = '0;
			thr_low = LOW_THRESHOLD_RST;
			thr_high = HIGH_THRESHOLD_RST;
			fail_count = 0;
			page_results.delete();
		end else begin
			// Register writes; an unknown index changes nothing.
			if (cfg_we) begin
				case (cfg_index)
					REG_LEVEL_OVERRIDE: override_lvl = cfg_data[LEVEL_W-1:0];
					REG_LOW_THRESHOLD:  thr_low = cfg_data[ENT_W-1:0];
					REG_HIGH_THRESHOLD: thr_high = cfg_data[ENT_W-1:0];
					default: ;
				endcase
			end

			// Result transfer: compare with the oldest expected page.
			if (m_axis_tvalid && m_axis_tready) begin
				got.level = m_axis_tdata[4:0];
				got.entropy = m_axis_tdata[16:5];
				got.length = m_axis_tdata[29:17];
				if (page_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h", $time, got);
					fail_count++;
				end else begin
					want = page_results.pop_front();
					if (got.level !== want.level) begin
						$display("%0t: chosen_level expected %0d actual %0d",
							$time, want.level, got.level);
						fail_count++;
					end
					if (got.entropy !== want.entropy) begin
						$display("%0t: entropy_q8 expected %0d actual %0d",
							$time, want.entropy, got.entropy);
						fail_count++;
					end
					if (got.length !== want.length) begin
						$display("%0t: page_length expected %0d actual %0d",
							$time, want.length, got.length);
						fail_count++;
					end
				end
			end

			// Byte transfer: count it unless the page is full; close the page on last.
			if (s_axis_tvalid && s_axis_tready) begin
				if (bytes_seen < PAGE_BYTES) begin
					bin_count[s_axis_tdata]++;
					bytes_seen++;
				end
				if (s_axis_tlast) begin
					want.entropy = entropy_of_page();
					if (override_lvl != 0)
						want.level = (override_lvl > LEVEL_MAX) ? LEVEL_MAX : override_lvl;
					else if (want.entropy < thr_low)
						want.level = LEVEL_FAST;
					else if (want.entropy < thr_high)
						want.level = LEVEL_MID;
					else
						want.level = LEVEL_HIGH;
					want.length = (bytes_seen > LEN_MAX) ? LEN_MAX : bytes_seen[LEN_W-1:0];
					page_results.push_back(want);
					foreach (bin_count[i])
						bin_count[i] = 0;
					bytes_seen = 0;
				end
			end
		end
	end

endmodule

// ----- bench/entropy_compression_level_select_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Entropy level select testbench
// Streams directed and random pages into the block under three idling
// patterns and several register settings; the checker judges every result.
// ----------------------------------------------------------------------------
module entropy_compression_level_select_top_tb;
	import ecls_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int WALK_CYCLES = 6000;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [7:0] data_byte
	logic                   s_axis_tlast;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [4:0] chosen_level, [16:5] entropy_q8,
	                                        // [29:17] page_length
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	int                     fail_count;
	int                     pending_pages;
	int                     tx_idle_pct;
	int                     rx_idle_pct;
	int                     bytes_sent;
	int unsigned            cycle_count;

	entropy_compression_level_select_top dut (.*);

	entropy_compression_level_select_checker checker_i (.*);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// The receiver stalls at random at the current rate.
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// One byte transfer, with random idle cycles before it.
	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		bytes_sent++;
	endtask

	// Hold the sender until every page result has been taken and the block is quiet.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_pages != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// A page of random length drawn from an alphabet of random width.
	task automatic send_random_page();
		int len;
		int base;
		int span;
		len = ($urandom_range(9) == 0) ? $urandom_range(41, 300) : $urandom_range(1, 40);
		base = $urandom_range(255);
		case ($urandom_range(3))
			0: span = 1;
			1: span = 4;
			2: span = 16;
			default: span = 256;
		endcase
		for (int i = 0; i < len; i++)
			send_byte(8'(base + $urandom_range(span - 1)), i == len - 1);
	endtask

	task automatic random_pages(input int n_bytes);
		int stop_at;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at)
			send_random_page();
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		bytes_sent = 0;
		cycle_count = 0;
		tx_idle_pct = 25;
		rx_idle_pct = 74;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pages at reset settings: single byte, flat, two-valued.
		send_byte(8'h00, 1'b1);
		for (int i = 0; i < 256; i++)
			send_byte(8'(i), i == 255);
		for (int i = 0; i < 8; i++)
			send_byte(i[0] ? 8'hFF : 8'h55, i == 7);
		drain();

		// Override beyond the top level, then the top level itself.
		write_reg(REG_LEVEL_OVERRIDE, 12'd31);
		send_byte(8'hA5, 1'b1);
		for (int i = 0; i < 3; i++)
			send_byte(8'(i * 7), i == 2);
		drain();
		write_reg(REG_LEVEL_OVERRIDE, 12'd22);
		send_byte(8'h3C, 1'b1);
		drain();

		// Thresholds at zero force the highest level; an unused index is ignored.
		write_reg(REG_LEVEL_OVERRIDE, 12'd0);
		write_reg(REG_LOW_THRESHOLD, 12'd0);
		write_reg(REG_HIGH_THRESHOLD, 12'd0);
		write_reg(REG_UNUSED, 12'hFFF);
		random_pages(300);
		drain();

		// Reset thresholds with the roles swapped: receiver mostly ready, sender slow.
		write_reg(REG_LOW_THRESHOLD, LOW_THRESHOLD_RST);
		write_reg(REG_HIGH_THRESHOLD, HIGH_THRESHOLD_RST);
		tx_idle_pct = 74;
		rx_idle_pct = 25;
		random_pages(400);
		drain();

		// Thresholds at full scale force the lowest level, no idling.
		write_reg(REG_LOW_THRESHOLD, 12'hFFF);
		write_reg(REG_HIGH_THRESHOLD, 12'hFFF);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		random_pages(150);
		drain();

		// Thresholds spread across the range, then an odd override.
		write_reg(REG_LOW_THRESHOLD, 12'($urandom_range(200, 900)));
		write_reg(REG_HIGH_THRESHOLD, 12'($urandom_range(900, 2048)));
		random_pages(400);
		drain();
		write_reg(REG_LEVEL_OVERRIDE, 12'($urandom_range(1, 21)));
		random_pages(150);
		drain();

		repeat (WALK_CYCLES / 60) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/ecls_pkg.sv
rtl/ecls_ram.sv
rtl/ecls_log2.sv
rtl/ecls_dp.sv
rtl/ecls_ctrl.sv
rtl/entropy_compression_level_select_top.sv
bench/entropy_compression_level_select_checker.sv
bench/entropy_compression_level_select_top_tb.sv
